// ----- src/hrp_pkg.sv -----
// Shared types, codes and constants for the HTTP request header parser.
package hrp_pkg;

   localparam int LINE_BYTES_DEFAULT  = 1024;
   localparam int FIELD_BYTES_DEFAULT = 255;
   localparam int QUEUE_DEPTH         = 4;

   localparam int LENGTH_LABEL_LEN = 15;
   localparam int TYPE_LABEL_LEN   = 13;
   localparam int LENGTH_VALUE_COL = 16;
   localparam int TYPE_VALUE_COL   = 14;

   // labels stored lowercase, compared against case-folded input
   localparam logic [8*LENGTH_LABEL_LEN-1:0] LENGTH_LABEL = "content-length:";
   localparam logic [8*TYPE_LABEL_LEN-1:0]   TYPE_LABEL   = "content-type:";

   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_VT       = 8'h0B;
   localparam logic [7:0] CHAR_FF       = 8'h0C;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_GAP     = 3'd1,
      PH_URL     = 3'd2,
      PH_REST    = 3'd3,
      PH_HEADERS = 3'd4,
      PH_BODY    = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_METHOD = 3'd0,
      KIND_PATH   = 3'd1,
      KIND_QUERY  = 3'd2,
      KIND_TYPE   = 3'd3,
      KIND_BODY   = 3'd4,
      KIND_END    = 3'd5,
      KIND_DONE   = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      NUM_LEAD   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_STOP   = 2'd2
   } num_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value_byte;
      logic [31:0] body_length;
      logic        body_follows;
      logic        last;
   } rsp_item_type;

   // byte with its character classes, as handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic [7:0] folded;
      logic       is_blank;
      logic       is_cr;
      logic       is_lf;
      logic       is_digit;
      logic       is_question;
      logic       is_plus;
      logic       is_minus;
   } cls_item_type;

   function automatic logic [7:0] length_label_char(input logic [3:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < LENGTH_LABEL_LEN) begin
         ch = LENGTH_LABEL[8*(LENGTH_LABEL_LEN-1-int'(idx)) +: 8];
      end
      return ch;
   endfunction

   function automatic logic [7:0] type_label_char(input logic [3:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < TYPE_LABEL_LEN) begin
         ch = TYPE_LABEL[8*(TYPE_LABEL_LEN-1-int'(idx)) +: 8];
      end
      return ch;
   endfunction

endpackage

// ----- src/hrp_fifo.sv -----
// Short first-in first-out queue of packed items.
module hrp_fifo
   import hrp_pkg::*;
#(
   parameter type item_type = logic,
   parameter int  DEPTH     = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type head_item,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   item_type      mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/hrp_front.sv -----
// Front end: tags each incoming byte with its character classes.
module hrp_front
   import hrp_pkg::*;
(
   input  req_item_type req_item,
   output cls_item_type cls_item
);

   logic [7:0] b;

   assign b = req_item.data_byte;

   always_comb begin
      cls_item.data_byte     = b;
      cls_item.end_of_stream = req_item.end_of_stream;
      cls_item.folded        = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
      cls_item.is_blank      = (b == CHAR_SPACE) || (b == CHAR_TAB) ||
                               (b == CHAR_VT) || (b == CHAR_FF);
      cls_item.is_cr         = (b == CHAR_CR);
      cls_item.is_lf         = (b == CHAR_LF);
      cls_item.is_digit      = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      cls_item.is_question   = (b == CHAR_QUESTION);
      cls_item.is_plus       = (b == CHAR_PLUS);
      cls_item.is_minus      = (b == CHAR_MINUS);
   end

endmodule

// ----- src/hrp_core.sv -----
// Back end: request line, header and body state machine, one byte per cycle unless stalled.
module hrp_core
   import hrp_pkg::*;
#(
   parameter int LINE_BYTES  = LINE_BYTES_DEFAULT,
   parameter int FIELD_BYTES = FIELD_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cls_item_type item,
   input  logic         item_valid,
   output logic         item_pop,
   output logic         out_push,
   output rsp_item_type out_item,
   input  logic         out_full
);

   localparam int LW = $clog2(LINE_BYTES);
   localparam int TW = $clog2(FIELD_BYTES);
   localparam logic [LW-1:0] LINE_LIMIT  = LW'(LINE_BYTES - 1);
   localparam logic [TW-1:0] TOKEN_LIMIT = TW'(FIELD_BYTES - 1);
   localparam logic [LW-1:0] LEN_LABEL_COL  = LW'(LENGTH_LABEL_LEN);
   localparam logic [LW-1:0] TYPE_LABEL_COL = LW'(TYPE_LABEL_LEN);
   localparam logic [LW-1:0] LEN_VALUE_COL  = LW'(LENGTH_VALUE_COL);
   localparam logic [LW-1:0] TYPE_VAL_COL   = LW'(TYPE_VALUE_COL);
   localparam logic [35:0]   MAX_LENGTH     = 36'hFFFFFFFF;

   phase_type     phase_ff, phase_in;
   logic [LW-1:0] line_pos_ff, line_pos_in;
   logic [TW-1:0] tok_ff, tok_in;
   logic          prev_cr_ff, prev_cr_in;
   logic          in_query_ff, in_query_in;
   logic          len_match_ff, len_match_in;
   logic          type_match_ff, type_match_in;
   num_phase_type num_phase_ff, num_phase_in;
   logic          num_neg_ff, num_neg_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   held_ff, held_in;
   logic          type_seen_ff, type_seen_in;
   logic [31:0]   remain_ff, remain_in;

   // shared decode
   logic          go, lf, ends, first_line, gap_start, tok_full, skip_lf;
   logic [LW-1:0] col, pos_inc;
   phase_type     eff_phase;
   logic [TW-1:0] eff_tok;
   kind_type      url_kind;
   logic          len_match_new, type_match_new, num_en;
   num_phase_type num_phase_step;
   logic          num_neg_step;
   logic [31:0]   acc_step, acc_sat;
   logic [35:0]   acc_times10;
   logic [31:0]   held_settle, eos_held, remain_dec;
   logic          seen_settle, header_follows, typed_end, type_char;

   assign go         = item_valid && !out_full;
   assign item_pop   = go;
   assign lf         = item.is_cr || item.is_lf;
   assign skip_lf    = prev_cr_ff && item.is_lf;
   assign col        = line_pos_ff;
   assign pos_inc    = line_pos_ff + 1'b1;
   assign ends       = lf || (pos_inc >= LINE_LIMIT);
   assign first_line = (phase_ff == PH_METHOD) || (phase_ff == PH_GAP) ||
                       (phase_ff == PH_URL) || (phase_ff == PH_REST);
   assign gap_start  = (phase_ff == PH_GAP) && !ends && !item.is_blank;
   assign eff_phase  = gap_start ? PH_URL : phase_ff;
   assign eff_tok    = gap_start ? '0 : tok_ff;
   assign tok_full   = (eff_tok >= TOKEN_LIMIT);
   assign url_kind   = in_query_ff ? KIND_QUERY : KIND_PATH;

   // header name matching, case folded
   assign len_match_new  = len_match_ff &&
      !((col < LEN_LABEL_COL) && (item.folded != length_label_char(col[3:0])));
   assign type_match_new = type_match_ff &&
      !((col < TYPE_LABEL_COL) && (item.folded != type_label_char(col[3:0])));

   // decimal length: acc * 10 + digit, saturating
   assign num_en      = !lf && (col >= LEN_VALUE_COL) && len_match_new;
   assign acc_times10 = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                        36'(item.data_byte[3:0]);
   assign acc_sat     = (acc_times10 > MAX_LENGTH) ? '1 : acc_times10[31:0];

   always_comb begin
      num_phase_step = num_phase_ff;
      num_neg_step   = num_neg_ff;
      acc_step       = acc_ff;
      if (num_en) begin
         unique case (num_phase_ff)
            NUM_LEAD: begin
               if (item.is_blank) begin
                  num_phase_step = NUM_LEAD;
               end else if (item.is_plus) begin
                  num_phase_step = NUM_DIGITS;
               end else if (item.is_minus) begin
                  num_phase_step = NUM_DIGITS;
                  num_neg_step   = 1'b1;
               end else if (item.is_digit) begin
                  num_phase_step = NUM_DIGITS;
                  acc_step       = acc_sat;
               end else begin
                  num_phase_step = NUM_STOP;
               end
            end
            NUM_DIGITS: begin
               if (item.is_digit) begin
                  acc_step = acc_sat;
               end else begin
                  num_phase_step = NUM_STOP;
               end
            end
            default: begin
               num_phase_step = num_phase_ff;
            end
         endcase
      end
   end

   // line end settles length and type; stream end settles a pending length line
   assign held_settle = (len_match_new && pos_inc >= LEN_LABEL_COL) ?
                        (num_neg_step ? '0 : acc_step) : held_ff;
   assign seen_settle = (type_match_new && pos_inc >= TYPE_LABEL_COL) ?
                        (pos_inc >= LEN_LABEL_COL) : type_seen_ff;
   assign eos_held    = ((phase_ff == PH_HEADERS) && len_match_ff &&
                         line_pos_ff >= LEN_LABEL_COL) ?
                        (num_neg_ff ? '0 : acc_ff) : held_ff;
   assign header_follows = type_seen_ff && (held_ff != '0);
   assign typed_end      = type_match_new && (pos_inc >= TYPE_LABEL_COL);
   assign type_char      = type_match_new && (col >= TYPE_VAL_COL) && !tok_full;
   assign remain_dec     = remain_ff - 32'(remain_ff != '0);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      line_pos_in   = line_pos_ff;
      tok_in        = tok_ff;
      prev_cr_in    = prev_cr_ff;
      in_query_in   = in_query_ff;
      len_match_in  = len_match_ff;
      type_match_in = type_match_ff;
      num_phase_in  = num_phase_ff;
      num_neg_in    = num_neg_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      type_seen_in  = type_seen_ff;
      remain_in     = remain_ff;
      if (go && phase_ff != PH_DONE) begin
         if (item.end_of_stream) begin
            prev_cr_in = 1'b0;
            phase_in   = PH_DONE;
            if (phase_ff != PH_BODY) begin
               held_in = eos_held;
            end
         end else if (skip_lf) begin
            prev_cr_in = 1'b0;
         end else if (phase_ff == PH_BODY) begin
            prev_cr_in = 1'b0;
            remain_in  = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_DONE;
            end
         end else begin
            prev_cr_in  = item.is_cr;
            line_pos_in = pos_inc;
            if (first_line) begin
               if (ends) begin
                  phase_in      = PH_HEADERS;
                  line_pos_in   = '0;
                  tok_in        = '0;
                  len_match_in  = 1'b1;
                  type_match_in = 1'b1;
                  num_phase_in  = NUM_LEAD;
                  num_neg_in    = 1'b0;
                  acc_in        = '0;
               end else if (item.is_blank) begin
                  if (phase_ff == PH_METHOD) begin
                     phase_in = PH_GAP;
                  end else if (phase_ff == PH_URL) begin
                     phase_in = PH_REST;
                  end
               end else begin
                  phase_in = eff_phase;
                  tok_in   = eff_tok;
                  if ((eff_phase == PH_METHOD || eff_phase == PH_URL) && !tok_full) begin
                     tok_in = eff_tok + 1'b1;
                     if (eff_phase == PH_URL && item.is_question) begin
                        in_query_in = 1'b1;
                     end
                  end
               end
            end else begin
               len_match_in  = len_match_new;
               type_match_in = type_match_new;
               num_phase_in  = num_phase_step;
               num_neg_in    = num_neg_step;
               acc_in        = acc_step;
               if (ends) begin
                  if (lf && col == '0) begin
                     if (header_follows) begin
                        phase_in  = PH_BODY;
                        remain_in = held_ff;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     held_in       = held_settle;
                     type_seen_in  = seen_settle;
                     line_pos_in   = '0;
                     tok_in        = '0;
                     len_match_in  = 1'b1;
                     type_match_in = 1'b1;
                     num_phase_in  = NUM_LEAD;
                     num_neg_in    = 1'b0;
                     acc_in        = '0;
                  end
               end else if (type_char) begin
                  tok_in = tok_ff + 1'b1;
               end
            end
         end
      end
   end

   // result
   always_comb begin
      out_push              = 1'b0;
      out_item.kind         = KIND_METHOD;
      out_item.value_byte   = '0;
      out_item.body_length  = '0;
      out_item.body_follows = 1'b0;
      out_item.last         = 1'b0;
      if (go && phase_ff != PH_DONE) begin
         if (item.end_of_stream) begin
            if (phase_ff != PH_BODY) begin
               out_push             = 1'b1;
               out_item.kind        = KIND_DONE;
               out_item.body_length = eos_held;
               out_item.last        = 1'b1;
            end
         end else if (skip_lf) begin
            out_push = 1'b0;
         end else if (phase_ff == PH_BODY) begin
            out_push            = 1'b1;
            out_item.kind       = KIND_BODY;
            out_item.value_byte = item.data_byte;
            out_item.last       = (remain_dec == '0);
         end else if (first_line) begin
            if (ends || item.is_blank) begin
               if (eff_phase == PH_METHOD) begin
                  out_push            = 1'b1;
                  out_item.kind       = KIND_END;
                  out_item.value_byte = 8'(KIND_METHOD);
               end else if (eff_phase == PH_URL) begin
                  out_push            = 1'b1;
                  out_item.kind       = KIND_END;
                  out_item.value_byte = 8'(url_kind);
               end
            end else if (eff_phase == PH_METHOD && !tok_full) begin
               out_push            = 1'b1;
               out_item.kind       = KIND_METHOD;
               out_item.value_byte = item.data_byte;
            end else if (eff_phase == PH_URL && !tok_full) begin
               out_push = 1'b1;
               if (item.is_question && !in_query_ff) begin
                  out_item.kind       = KIND_END;
                  out_item.value_byte = 8'(KIND_PATH);
               end else begin
                  out_item.kind       = url_kind;
                  out_item.value_byte = item.data_byte;
               end
            end
         end else begin
            if (ends) begin
               if (lf && col == '0) begin
                  out_push              = 1'b1;
                  out_item.kind         = KIND_DONE;
                  out_item.body_length  = held_ff;
                  out_item.body_follows = header_follows;
                  out_item.last         = !header_follows;
               end else if (typed_end) begin
                  out_push            = 1'b1;
                  out_item.kind       = KIND_END;
                  out_item.value_byte = 8'(KIND_TYPE);
               end
            end else if (type_char) begin
               out_push            = 1'b1;
               out_item.kind       = KIND_TYPE;
               out_item.value_byte = item.data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_METHOD;
         line_pos_ff   <= '0;
         tok_ff        <= '0;
         prev_cr_ff    <= 1'b0;
         in_query_ff   <= 1'b0;
         len_match_ff  <= 1'b1;
         type_match_ff <= 1'b1;
         num_phase_ff  <= NUM_LEAD;
         num_neg_ff    <= 1'b0;
         acc_ff        <= '0;
         held_ff       <= '0;
         type_seen_ff  <= 1'b0;
         remain_ff     <= '0;
      end else begin
         phase_ff      <= phase_in;
         line_pos_ff   <= line_pos_in;
         tok_ff        <= tok_in;
         prev_cr_ff    <= prev_cr_in;
         in_query_ff   <= in_query_in;
         len_match_ff  <= len_match_in;
         type_match_ff <= type_match_in;
         num_phase_ff  <= num_phase_in;
         num_neg_ff    <= num_neg_in;
         acc_ff        <= acc_in;
         held_ff       <= held_in;
         type_seen_ff  <= type_seen_in;
         remain_ff     <= remain_in;
      end
   end

endmodule

// ----- src/http_request_header_parser.sv -----
// Top level of the streaming HTTP request header parser.
// Usage:
//   Input queue side: drive req_item (data_byte, end_of_stream) and push;
//   an item is taken at a clock edge with push high and full low.
//   Result queue side: while empty is low, rsp_item holds the oldest result;
//   pop high with empty low takes it.
// Data path: the front end tags each byte with its character classes and
//   writes it into a short queue; the back end state machine takes one byte
//   per cycle from that queue while the output queue has room, and writes at
//   most one result into the output queue.
// Throughput: one item per cycle, sustained while pop keeps the output queue
//   from filling.
// Path: a result passes the front queue, then the output queue, to rsp_item;
//   the back end reads the front queue and writes the output queue at one edge.
// Stall: when pop stays low the output queue fills, the back end holds, and
//   the front queue fills in turn; full then goes high.
// Reset (synchronous, active high): both queues empty, parser back to the
//   start of a request. After the request completes all further items are
//   taken and dropped until the next reset.
module http_request_header_parser
   import hrp_pkg::*;
#(
   parameter int LINE_BYTES  = LINE_BYTES_DEFAULT,
   parameter int FIELD_BYTES = FIELD_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   cls_item_type cls_item;
   cls_item_type mid_head;
   logic         mid_empty;
   logic         mid_pop;
   logic         out_push;
   logic         out_full;
   rsp_item_type out_item;

   // classify the byte on its way in
   hrp_front u_front (
      .req_item (req_item),
      .cls_item (cls_item)
   );

   // decouples intake from the parser
   hrp_fifo #(
      .item_type (cls_item_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (cls_item),
      .full      (full),
      .pop       (mid_pop),
      .head_item (mid_head),
      .empty     (mid_empty)
   );

   // parser: runs whenever a byte waits and the output queue has room
   hrp_core #(
      .LINE_BYTES  (LINE_BYTES),
      .FIELD_BYTES (FIELD_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item       (mid_head),
      .item_valid (!mid_empty),
      .item_pop   (mid_pop),
      .out_push   (out_push),
      .out_item   (out_item),
      .out_full   (out_full)
   );

   // results wait here for the receiver
   hrp_fifo #(
      .item_type (rsp_item_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (pop),
      .head_item (rsp_item),
      .empty     (empty)
   );

endmodule
